### design/rbps_pkg.sv
// Shared types, constants and table functions of the rotating band projection shader.
// Used by the channel interfaces and by every module of the core; depends on nothing.
package rbps_pkg;

   localparam int LEDS_DEFAULT        = 32;
   localparam int ANGLE_UNITS_DEFAULT = 3600;

   // Payload widths
   localparam int DELTA_W  = 24;
   localparam int ANGLE_W  = 12;
   localparam int LED_W    = 6;
   localparam int COLOR_W  = 8;
   localparam int RADIUS_W = 8;

   // Register port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTER = 1'b1;
   localparam logic [RADIUS_W-1:0] INNER_RESET = 8'd20;
   localparam logic [RADIUS_W-1:0] OUTER_RESET = 8'd202;

   // Time scaling: angle units = delta_us * 36 / 100000
   localparam int SCALED_W = 30;
   localparam logic [5:0] US_TO_ANGLE_MUL = 6'd36;

   // Serial divider, two quotient bits per cycle
   localparam int DIV_NUM_W   = 30;
   localparam int DIV_DEN_W   = 17;
   localparam int DIV_Q_W     = 14;
   localparam int DIV_PAIRS_W = 3;
   localparam logic [DIV_DEN_W-1:0]   US_PER_STEP = 17'd100000;
   localparam logic [DIV_PAIRS_W-1:0] PAIRS_TIME  = 3'd7;
   localparam logic [DIV_PAIRS_W-1:0] PAIRS_WRAP  = 3'd3;
   localparam logic [DIV_PAIRS_W-1:0] PAIRS_BYTE  = 3'd4;

   localparam int QUEUE_DEPTH = 2;

   localparam int BAND_COUNT = 8;
   localparam logic [2:0] LAST_BAND = 3'(BAND_COUNT - 1);

   typedef enum logic {
      FUNC_TIME = 1'b0,
      FUNC_ARM  = 1'b1
   } func_type;

   typedef struct packed {
      logic                 func;
      logic [DELTA_W-1:0]   delta_us;
      logic [ANGLE_W-1:0]   arm_angle;
   } req_payload_type;

   typedef struct packed {
      logic [LED_W-1:0]     led_index;
      logic [COLOR_W-1:0]   red;
      logic [COLOR_W-1:0]   green;
      logic [COLOR_W-1:0]   blue;
      logic                 last;
   } rsp_payload_type;

   typedef struct packed {
      func_type             kind;
      logic [SCALED_W-1:0]  operand;
   } cmd_type;

   typedef struct packed {
      logic                 push;
      cmd_type              cmd;
   } queue_push_type;

   typedef struct packed {
      logic                 empty;
      cmd_type              head;
   } queue_status_type;

   typedef struct packed {
      logic [RADIUS_W-1:0]  inner;
      logic [RADIUS_W-1:0]  outer;
   } cfg_type;

   typedef struct packed {
      logic                   start;
      logic [DIV_NUM_W-1:0]   num;
      logic [DIV_DEN_W-1:0]   den;
      logic [DIV_PAIRS_W-1:0] pairs;
   } div_req_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic [DIV_Q_W-1:0]     quot;
      logic [DIV_NUM_W-1:0]   rem;
   } div_rsp_type;

   // Band palette as {red, green, blue}
   function automatic logic [23:0] band_color(input logic [2:0] band);
      logic [23:0] rgb;
      case (band)
         3'd0:    rgb = {8'd240, 8'd220, 8'd190};
         3'd1:    rgb = {8'd180, 8'd100, 8'd60};
         3'd2:    rgb = {8'd255, 8'd240, 8'd220};
         3'd3:    rgb = {8'd120, 8'd70,  8'd40};
         3'd4:    rgb = {8'd230, 8'd180, 8'd140};
         3'd5:    rgb = {8'd200, 8'd80,  8'd50};
         3'd6:    rgb = {8'd250, 8'd235, 8'd200};
         default: rgb = {8'd90,  8'd50,  8'd30};
      endcase
      return rgb;
   endfunction

   // Blend weight for the four fractional steps that fall inside a band's edge
   function automatic logic [7:0] blend_amount(input logic [1:0] step);
      logic [7:0] amt;
      case (step)
         2'd0:    amt = 8'd7;
         2'd1:    amt = 8'd71;
         2'd2:    amt = 8'd135;
         default: amt = 8'd199;
      endcase
      return amt;
   endfunction

   // Piecewise 8-bit sine, full turn over 0..255, centered on 128
   function automatic logic [7:0] sine8(input logic [7:0] theta);
      logic [7:0]  off;
      logic [4:0]  sec;
      logic [7:0]  base;
      logic [7:0]  slope;
      logic [12:0] prod;
      logic [7:0]  y;
      off = theta[6] ? ~theta : theta;
      sec = {1'b0, off[3:0]} + {4'b0, theta[6]};
      case (off[5:4])
         2'd0:    begin base = 8'd0;   slope = 8'd49; end
         2'd1:    begin base = 8'd49;  slope = 8'd41; end
         2'd2:    begin base = 8'd90;  slope = 8'd27; end
         default: begin base = 8'd117; slope = 8'd10; end
      endcase
      prod = 13'(slope) * 13'(sec);
      y = prod[11:4] + base;
      if (theta[7]) begin
         y = 8'd0 - y;
      end
      return y + 8'd128;
   endfunction

   // Per-channel blend, a*256 + b + (b - a)*amt kept to 16 bits, high byte
   function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] amt);
      logic signed [18:0] diff;
      logic signed [18:0] prod;
      logic signed [18:0] sum;
      diff = $signed({11'b0, b}) - $signed({11'b0, a});
      prod = diff * $signed({11'b0, amt});
      sum  = $signed({3'b000, a, b}) + prod;
      return sum[15:8];
   endfunction

   function automatic logic [23:0] pixel_color(input logic [7:0] yn);
      logic [2:0]  band;
      logic [23:0] lo;
      logic [23:0] hi;
      logic [7:0]  amt;
      logic [23:0] mixed;
      band  = yn[7:5];
      lo    = band_color(band);
      hi    = band_color(band + 3'd1);
      amt   = blend_amount(yn[1:0]);
      mixed = {mix8(lo[23:16], hi[23:16], amt),
               mix8(lo[15:8],  hi[15:8],  amt),
               mix8(lo[7:0],   hi[7:0],   amt)};
      // top four fractional steps of a band fade toward the next band
      return (yn[4:2] == 3'b111 && band != LAST_BAND) ? mixed : lo;
   endfunction

endpackage

### design/rbps_if.sv
// Request and response channel interfaces of the shader core.
// Depends on rbps_pkg for the payload structs.
interface rbps_req_if import rbps_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rbps_rsp_if import rbps_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### design/rbps_front.sv
// Front end: accepts requests, classifies them and scales time deltas.
// Depends on rbps_pkg and rbps_req_if; feeds rbps_queue.
module rbps_front import rbps_pkg::*; (
   rbps_req_if.sink        req_if,
   input  logic            queue_full,
   output queue_push_type  push_out
);

   logic [SCALED_W-1:0] scaled;

   assign req_if.ready = !queue_full;

   always_comb begin
      scaled = SCALED_W'(req_if.payload.delta_us) * SCALED_W'(US_TO_ANGLE_MUL);
      push_out.push     = req_if.valid && !queue_full;
      push_out.cmd.kind = func_type'(req_if.payload.func);
      if (req_if.payload.func == FUNC_TIME) begin
         push_out.cmd.operand = scaled;
      end else begin
         push_out.cmd.operand = SCALED_W'(req_if.payload.arm_angle);
      end
   end

endmodule

### design/rbps_queue.sv
// Short command queue between front and back end.
// Depends on rbps_pkg.
module rbps_queue import rbps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_push_type   push_in,
   output logic             full,
   input  logic             pop,
   output queue_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full          = (count_ff == DEPTH_CNT);
   assign status.empty  = (count_ff == '0);
   assign status.head   = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push_in.push && !full;
      do_pop    = pop && !status.empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_in.cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count beyond depth");

endmodule

### design/rbps_div.sv
// Shared restoring divider, two quotient bits per cycle, caller sets the bit count.
// Depends on rbps_pkg; used by rbps_back for every division of the core.
module rbps_div import rbps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_PAIRS_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0]   rem_ff, rem_in;
   logic [DIV_NUM_W-1:0]   den_sh_ff, den_sh_in;
   logic [DIV_Q_W-1:0]     quot_ff, quot_in;
   logic [DIV_NUM_W-1:0]   den_lo;
   logic [DIV_NUM_W-1:0]   rem_mid;
   logic                   bit_hi;
   logic                   bit_lo;
   logic [DIV_PAIRS_W:0]   shift;

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      den_sh_in = den_sh_ff;
      quot_in   = quot_ff;
      shift     = {req.pairs, 1'b0} - 1'b1;
      den_lo    = den_sh_ff >> 1;
      bit_hi    = (rem_ff >= den_sh_ff);
      rem_mid   = bit_hi ? rem_ff - den_sh_ff : rem_ff;
      bit_lo    = (rem_mid >= den_lo);
      if (req.start) begin
         // align divisor under the top quotient bit
         rem_in    = req.num;
         den_sh_in = DIV_NUM_W'(req.den) << shift;
         cnt_in    = req.pairs;
         quot_in   = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         rem_in    = bit_lo ? rem_mid - den_lo : rem_mid;
         den_sh_in = den_sh_ff >> 2;
         quot_in   = {quot_ff[DIV_Q_W-3:0], bit_hi, bit_lo};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == DIV_PAIRS_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff    <= rem_in;
      den_sh_ff <= den_sh_in;
      quot_ff   <= quot_in;
   end

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with no steps left");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

### design/rbps_back.sv
// Back end: sequencer that owns the rotation offset, renders one pixel at a time
// through the shared divider and holds the response register. Depends on rbps_pkg.
module rbps_back import rbps_pkg::*; #(
   parameter int LEDS        = LEDS_DEFAULT,
   parameter int ANGLE_UNITS = ANGLE_UNITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  queue_status_type queue_status,
   output logic             queue_pop,
   output div_req_type      div_req,
   input  div_rsp_type      div_rsp,
   rbps_rsp_if.source       rsp_if
);

   localparam logic [ANGLE_W-1:0]   AU       = ANGLE_W'(ANGLE_UNITS);
   localparam logic [LED_W-1:0]     LAST_LED = LED_W'(LEDS - 1);
   localparam logic [DIV_DEN_W-1:0] RAD_DEN  = DIV_DEN_W'(LEDS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_TIME_DIV,
      S_TIME_WRAP,
      S_ARM_WRAP,
      S_ARM_ANGLE,
      S_RAD_ISSUE,
      S_RAD_WAIT,
      S_HEIGHT,
      S_NORM_ISSUE,
      S_NORM_WAIT,
      S_COLOR,
      S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [ANGLE_W-1:0]     rotation_ff, rotation_in;
   logic [LED_W-1:0]       led_ff, led_in;
   logic signed [7:0]      sc_ff, sc_in;
   logic [RADIUS_W-1:0]    span_mag_ff, span_mag_in;
   logic                   span_neg_ff, span_neg_in;
   logic [RADIUS_W-1:0]    radius_ff, radius_in;
   logic [9:0]             y_ff, y_in;
   logic [7:0]             yn_ff, yn_in;
   logic [23:0]            color_ff, color_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic [8:0]             span;
   logic [13:0]            rad_prod;
   logic signed [16:0]     height_prod;
   logic signed [16:0]     height_adj;
   logic [18:0]            norm_base;
   logic [18:0]            norm_num;
   logic [8:0]             norm_den;
   logic                   out_free;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      rotation_in  = rotation_ff;
      led_in       = led_ff;
      sc_in        = sc_ff;
      span_mag_in  = span_mag_ff;
      span_neg_in  = span_neg_ff;
      radius_in    = radius_ff;
      y_in         = y_ff;
      yn_in        = yn_ff;
      color_in     = color_ff;
      rsp_data_in  = rsp_data_ff;
      queue_pop    = 1'b0;
      div_req      = '{start: 1'b0, num: '0, den: '0, pairs: '0};

      out_free     = !rsp_valid_ff || rsp_if.ready;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      span        = {1'b0, cfg.outer} - {1'b0, cfg.inner};
      rad_prod    = 14'(led_ff) * 14'(span_mag_ff);
      height_prod = $signed({1'b0, radius_ff}) * sc_ff;
      // truncate toward zero before the divide by 128
      height_adj  = height_prod + (height_prod[16] ? 17'sd127 : 17'sd0);
      norm_base   = {{9{y_ff[9]}}, y_ff} + {11'b0, cfg.outer};
      norm_num    = (norm_base << 8) - norm_base;
      norm_den    = (cfg.outer == '0) ? 9'd2 : {cfg.outer, 1'b0};

      case (state_ff)
         S_IDLE: begin
            span_neg_in = span[8];
            span_mag_in = span[8] ? 8'(9'd0 - span) : span[7:0];
            if (!queue_status.empty) begin
               queue_pop = 1'b1;
               div_req.start = 1'b1;
               if (queue_status.head.kind == FUNC_TIME) begin
                  div_req.num   = queue_status.head.operand;
                  div_req.den   = US_PER_STEP;
                  div_req.pairs = PAIRS_TIME;
                  state_in      = S_TIME_DIV;
               end else begin
                  div_req.num   = DIV_NUM_W'(queue_status.head.operand[ANGLE_W-1:0])
                                + DIV_NUM_W'(rotation_ff);
                  div_req.den   = DIV_DEN_W'(AU);
                  div_req.pairs = PAIRS_WRAP;
                  state_in      = S_ARM_WRAP;
               end
            end
         end
         S_TIME_DIV: begin
            if (div_rsp.done) begin
               div_req.start = 1'b1;
               div_req.num   = DIV_NUM_W'(div_rsp.quot) + DIV_NUM_W'(rotation_ff);
               div_req.den   = DIV_DEN_W'(AU);
               div_req.pairs = PAIRS_WRAP;
               state_in      = S_TIME_WRAP;
            end
         end
         S_TIME_WRAP: begin
            if (div_rsp.done) begin
               rotation_in = div_rsp.rem[ANGLE_W-1:0];
               state_in    = S_IDLE;
            end
         end
         S_ARM_WRAP: begin
            if (div_rsp.done) begin
               // scale the wrapped angle to a byte-sized turn
               div_req.start = 1'b1;
               div_req.num   = DIV_NUM_W'({div_rsp.rem[ANGLE_W-1:0], 8'h00});
               div_req.den   = DIV_DEN_W'(AU);
               div_req.pairs = PAIRS_BYTE;
               state_in      = S_ARM_ANGLE;
            end
         end
         S_ARM_ANGLE: begin
            if (div_rsp.done) begin
               sc_in    = $signed(sine8(div_rsp.quot[7:0]) ^ 8'h80);
               led_in   = '0;
               state_in = S_RAD_ISSUE;
            end
         end
         S_RAD_ISSUE: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(rad_prod);
            div_req.den   = RAD_DEN;
            div_req.pairs = PAIRS_BYTE;
            state_in      = S_RAD_WAIT;
         end
         S_RAD_WAIT: begin
            if (div_rsp.done) begin
               radius_in = span_neg_ff ? cfg.inner - div_rsp.quot[7:0]
                                       : cfg.inner + div_rsp.quot[7:0];
               state_in  = S_HEIGHT;
            end
         end
         S_HEIGHT: begin
            y_in     = height_adj[16:7];
            state_in = S_NORM_ISSUE;
         end
         S_NORM_ISSUE: begin
            if (norm_num[18] || norm_num == '0) begin
               yn_in    = 8'd0;
               state_in = S_COLOR;
            end else if (norm_num[17:0] >= 18'({norm_den, 8'h00})) begin
               yn_in    = 8'd255;
               state_in = S_COLOR;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = DIV_NUM_W'(norm_num[17:0]);
               div_req.den   = DIV_DEN_W'(norm_den);
               div_req.pairs = PAIRS_BYTE;
               state_in      = S_NORM_WAIT;
            end
         end
         S_NORM_WAIT: begin
            if (div_rsp.done) begin
               yn_in    = div_rsp.quot[7:0];
               state_in = S_COLOR;
            end
         end
         S_COLOR: begin
            color_in = pixel_color(yn_ff);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // hold until the response register frees up
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.led_index = led_ff;
               rsp_data_in.red       = color_ff[23:16];
               rsp_data_in.green     = color_ff[15:8];
               rsp_data_in.blue      = color_ff[7:0];
               rsp_data_in.last      = (led_ff == LAST_LED);
               if (led_ff == LAST_LED) begin
                  state_in = S_IDLE;
               end else begin
                  led_in   = led_ff + 1'b1;
                  state_in = S_RAD_ISSUE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rotation_ff  <= '0;
         led_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rotation_ff  <= rotation_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sc_ff       <= sc_in;
      span_mag_ff <= span_mag_in;
      span_neg_ff <= span_neg_in;
      radius_ff   <= radius_in;
      y_ff        <= y_in;
      yn_ff       <= yn_in;
      color_ff    <= color_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_rotation_range: assert property (@(posedge clock) disable iff (reset)
      rotation_ff < AU)
      else $error("rotation offset out of range");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_rotation_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_TIME_WRAP |=> $stable(rotation_ff))
      else $error("rotation changed outside a time update");

endmodule

### design/rotating_band_projection_shader_core.sv
// Rotating band projection shader core. A request with func 0 advances the
// rotation offset by delta_us*36/100000 angle units and returns nothing. A
// request with func 1 returns LEDS pixels, innermost first, with last set on
// the final one. Its pace is set by the single shared divider, which the back
// end drives; it yields two quotient bits per cycle and runs twice per pixel,
// once when the height clamps. A two-entry queue lets the next requests be
// accepted while the back end renders, and the response register lets the
// back end go on with the next pixel while a finished one waits. Write the
// radius registers only while the core is idle.
module rotating_band_projection_shader_core import rbps_pkg::*; #(
   parameter int LEDS        = LEDS_DEFAULT,
   parameter int ANGLE_UNITS = ANGLE_UNITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   rbps_req_if.sink               req_if,
   rbps_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   queue_push_type   push;
   logic             queue_full;
   logic             queue_pop;
   queue_status_type queue_status;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_INNER: cfg_in.inner = csr_wdata;
            CSR_OUTER: cfg_in.outer = csr_wdata;
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{inner: INNER_RESET, outer: OUTER_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbps_front u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .push_out   (push)
   );

   rbps_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .full    (queue_full),
      .pop     (queue_pop),
      .status  (queue_status)
   );

   rbps_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   rbps_back #(
      .LEDS        (LEDS),
      .ANGLE_UNITS (ANGLE_UNITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .queue_status (queue_status),
      .queue_pop    (queue_pop),
      .div_req      (div_req),
      .div_rsp      (div_rsp),
      .rsp_if       (rsp_if)
   );

endmodule
